/* hw/rtl/wabs_pkg.sv */
package wabs_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int WLEN_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Default sizing of the window.
  localparam int WINDOW_MAX_DEF = 1024;
  localparam int MIN_FILL_DEF   = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  // Register reset values.
  localparam logic [GAIN_W-1:0] ALPHA_RST = 17'd32768;
  localparam logic [GAIN_W-1:0] BETA_RST  = 17'd0;
  localparam logic [WLEN_W-1:0] WLEN_RST  = 11'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // store the accepted sample and update window bookkeeping
    logic issue;     // read the next window entry into the filter pipeline
    logic first;     // the entry being read is the oldest of the window
    logic out_load;  // load the output register
    logic commit;    // the filter ran: take its final value as the held result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_ok;   // window holds enough samples to filter
    logic last;      // the read being issued is the newest entry
    logic done;      // the newest entry has passed through the filter
  } stat_t;

endpackage

/* hw/rtl/wabs_datapath.sv */
module wabs_datapath #(
  parameter int WINDOW_MAX = wabs_pkg::WINDOW_MAX_DEF,
  parameter int MIN_FILL   = wabs_pkg::MIN_FILL_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [wabs_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wabs_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  input  logic signed [wabs_pkg::SAMPLE_W-1:0]     in_sample,
  input  wabs_pkg::cmd_t                           cmd,
  output wabs_pkg::stat_t                          stat,
  output logic signed [wabs_pkg::SAMPLE_W-1:0]     smoothed_out
);
  import wabs_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int LIM_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int SUM_W  = CNT_W + 1;
  localparam int PROD_W = GAIN_W + 1 + SAMPLE_W + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - GAIN_FRAC;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
  localparam logic [LIM_W-1:0] WMAX_L   = LIM_W'(WINDOW_MAX);
  localparam logic [SUM_W-1:0] WMAX_S   = SUM_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] MIN_C    = CNT_W'(MIN_FILL);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (GAIN_FRAC - 1));
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(1 << (SAMPLE_W - 1));

  // Configuration registers.
  logic [GAIN_W-1:0] alpha_r;
  logic [GAIN_W-1:0] beta_r;
  logic [WLEN_W-1:0] wlen_r;

  // Window bookkeeping.
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] remain_r;
  logic [LIM_W-1:0] wlen_ext, limit;
  logic [LIM_W:0]   count_inc;
  logic [SUM_W-1:0] start_raw, start_wrap;

  // Sample memory.
  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rd_data_r;

  // Filter pipeline.
  logic                       s1_vld_r, s1_first_r, s1_last_r;
  logic                       s2_vld_r, s2_first_r, s2_last_r;
  logic signed [SAMPLE_W-1:0] prev_r, x2_r, y_r, y_nxt;
  logic signed [SAMPLE_W:0]   diff_b, diff_a;
  logic signed [PROD_W-1:0]   bprod, bterm_r, aprod;
  logic signed [ACC_W-1:0]    y_shift, acc;
  logic signed [Q_W-1:0]      q;
  logic                       done_r;

  // Held result and output register.
  logic signed [SAMPLE_W-1:0] held_r;
  logic signed [SAMPLE_W-1:0] out_r;

  // Effective window length, never above the store depth.
  assign wlen_ext = LIM_W'(wlen_r);
  assign limit    = (wlen_ext > WMAX_L) ? WMAX_L : wlen_ext;

  // Count grows until it would pass the limit; then the oldest sample is dropped.
  assign count_inc = {1'b0, LIM_W'(count_r)} + (LIM_W + 1)'(1);
  assign count_nxt = (count_inc > {1'b0, limit}) ? count_r : count_r + CNT_W'(1);
  assign wp_nxt    = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);

  // Oldest entry of the window after this write.
  assign start_raw  = SUM_W'(wp_nxt) + WMAX_S - SUM_W'(count_nxt);
  assign start_wrap = (start_raw >= WMAX_S) ? start_raw - WMAX_S : start_raw;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      beta_r  <= BETA_RST;
      wlen_r  <= WLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA_GAIN:    alpha_r <= cfg_wdata[GAIN_W-1:0];
        CFG_BETA_GAIN:     beta_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_WINDOW_LENGTH: wlen_r  <= cfg_wdata[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Write pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      count_r <= '0;
    end else if (cmd.load) begin
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  // Read address sequencing over the window.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ptr_r <= start_wrap[PTR_W-1:0];
      remain_r <= count_nxt - CNT_W'(1);
    end else if (cmd.issue) begin
      rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      remain_r <= remain_r - CNT_W'(1);
    end
  end

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wp_r] <= in_sample;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r && s2_last_r;
    end
  end

  // Stage one tags follow the read.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_first_r <= cmd.first;
      s1_last_r  <= stat.last;
    end
  end

  // Stage two: the sample difference term does not depend on y, so it is formed early.
  assign diff_b = {rd_data_r[SAMPLE_W-1], rd_data_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign bprod  = $signed({1'b0, beta_r}) * diff_b;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      prev_r     <= rd_data_r;
      x2_r       <= rd_data_r;
      bterm_r    <= bprod;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // Stage three: recursive update with round half up and saturation; the first entry of the window loads y directly.
  assign diff_a  = {x2_r[SAMPLE_W-1], x2_r} - {y_r[SAMPLE_W-1], y_r};
  assign aprod   = $signed({1'b0, alpha_r}) * diff_a;
  assign y_shift = $signed({{(ACC_W - SAMPLE_W - GAIN_FRAC){y_r[SAMPLE_W-1]}}, y_r,
                            {GAIN_FRAC{1'b0}}});
  assign acc     = y_shift + ACC_W'(aprod) + ACC_W'(bterm_r) + ROUND_HALF;
  assign q       = acc[ACC_W-1:GAIN_FRAC];

  always_comb begin
    if (q > SAT_HI) begin
      y_nxt = SAT_HI[SAMPLE_W-1:0];
    end else if (q < SAT_LO) begin
      y_nxt = SAT_LO[SAMPLE_W-1:0];
    end else begin
      y_nxt = q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      y_r <= s2_first_r ? x2_r : y_nxt;
    end
  end

  // Held result and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.commit) begin
      held_r <= y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= cmd.commit ? y_r : held_r;
    end
  end

  assign smoothed_out = out_r;

  // Status to the controller.
  assign stat.fill_ok = (count_r >= MIN_C);
  assign stat.last    = (remain_r == '0);
  assign stat.done    = done_r;

endmodule

/* hw/rtl/wabs_ctrl.sv */
module wabs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            filter_ran,
  output wabs_pkg::cmd_t  cmd,
  input  wabs_pkg::stat_t stat
);
  import wabs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   ran_r, ran_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_ran_r, out_ran_nxt;
  logic   can_load;

  // The output register can take a new result when empty or being emptied.
  assign can_load = !out_valid_r || !out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    ran_nxt       = ran_r;
    out_ran_nxt   = out_ran_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.fill_ok) begin
          first_nxt = 1'b1;
          ran_nxt   = 1'b1;
          state_nxt = ST_RUN;
        end else begin
          ran_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.first = first_r;
        first_nxt = 1'b0;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          cmd.out_load  = 1'b1;
          cmd.commit    = ran_r;
          out_valid_nxt = 1'b1;
          out_ran_nxt   = ran_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b0;
      ran_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_ran_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      ran_r       <= ran_nxt;
      out_valid_r <= out_valid_nxt;
      out_ran_r   <= out_ran_nxt;
    end
  end

  // No sample is taken while reset is held.
  assign in_stall   = (state_r != ST_IDLE) || !rst_n;
  assign out_valid  = out_valid_r;
  assign filter_ran = out_ran_r;

endmodule

/* hw/rtl/windowed_alpha_beta_smoother.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_sample_in (signed Q8.8)
// result    out_valid / out_stall  out_smoothed_out (signed Q8.8), out_filter_ran
// config    cfg_we                 cfg_index, cfg_wdata
//
// A new sample is accepted only when the previous one is finished. When the window
// holds n >= MIN_FILL samples the recursive filter runs over all n of them, reading one
// stored sample per cycle from the single read port of the sample memory; otherwise
// it does not run.
// Reset is synchronous and active low; in_stall is high during reset and the sample
// memory is not cleared.
// A result waiting under out_stall does not block acceptance of the next sample; the
// result of that sample waits in the datapath until the output register is free.
module windowed_alpha_beta_smoother #(
  parameter int WINDOW_MAX = wabs_pkg::WINDOW_MAX_DEF,
  parameter int MIN_FILL   = wabs_pkg::MIN_FILL_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wabs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wabs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wabs_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wabs_pkg::SAMPLE_W-1:0] out_smoothed_out,
  output logic                                 out_filter_ran
);
  import wabs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for one transaction at a time.
  wabs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .filter_ran (out_filter_ran),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Window store, filter pipeline and result registers.
  wabs_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .MIN_FILL   (MIN_FILL)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (in_sample_in),
    .cmd          (cmd),
    .stat         (stat),
    .smoothed_out (out_smoothed_out)
  );

endmodule
